@@ rtl/tdds_pkg.sv @@
package tdds_pkg;

   localparam int CELL_X_BITS = 8;
   localparam int CELL_Y_BITS = 8;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int ADDR_BITS   = CELL_X_BITS + CELL_Y_BITS;
   localparam int DIM_BITS    = 9;
   localparam int CSR_BITS    = 17;

   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE  = 2'd0;
   localparam op_type OP_READ   = 2'd1;
   localparam op_type OP_RUN    = 2'd2;
   localparam op_type OP_UNUSED = 2'd3;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_GRID_WIDTH  = 3'd0;
   localparam csr_index_type CSR_GRID_HEIGHT = 3'd1;
   localparam csr_index_type CSR_DIFF_GAIN   = 3'd2;
   localparam csr_index_type CSR_DECAY       = 3'd3;
   localparam csr_index_type CSR_TRAIL_LIMIT = 3'd4;
   localparam csr_index_type CSR_PASS_COUNT  = 3'd5;

   typedef struct packed {
      op_type                  op;
      logic [CELL_X_BITS-1:0] cell_x;
      logic [CELL_Y_BITS-1:0] cell_y;
      logic [15:0]             trail_in;
      logic                    wall_in;
   } req_type;

   typedef struct packed {
      logic [15:0] trail_out;
      logic        wall_out;
   } rsp_type;

   typedef struct packed {
      logic mul1;
      logic mul2;
      logic mul3;
   } math_ctl_type;

endpackage

@@ rtl/tdds_cell_math.sv @@
module tdds_cell_math (
   input  logic                clock,
   input  tdds_pkg::math_ctl_type ctl,
   input  logic [15:0]         center,
   input  logic [17:0]         nsum,
   input  logic [15:0]         gain,
   input  logic [16:0]         decay,
   input  logic [15:0]         limit,
   output logic [15:0]         result
);
   import tdds_pkg::*;

   logic signed [18:0] lap;
   logic signed [35:0] kprod;
   logic signed [35:0] s_ff;
   logic               pos_ff;
   logic [34:0]        plo_ff;
   logic [33:0]        phi_ff;
   logic [52:0]        prod;
   logic [52:0]        rnd;
   logic [20:0]        r;

   assign lap   = $signed({1'b0, nsum}) - $signed({1'b0, center, 2'b00});
   assign kprod = $signed({1'b0, gain}) * lap;

   always_ff @(posedge clock) begin
      if (ctl.mul1) begin
         s_ff <= $signed({4'b0, center, 16'b0}) + kprod;
      end
      if (ctl.mul2) begin
         pos_ff <= !s_ff[35] && (s_ff != 36'sd0);
         plo_ff <= s_ff[17:0] * decay;
      end
      if (ctl.mul3) begin
         phi_ff <= s_ff[34:18] * decay;
      end
   end

   assign prod = {1'b0, phi_ff, 18'b0} + {18'b0, plo_ff};
   assign rnd  = prod + (53'd1 << 31);
   assign r    = rnd[52:32];

   always_comb begin
      if (!pos_ff) begin
         result = 16'd0;
      end else if (r > {5'b0, limit}) begin
         result = limit;
      end else begin
         result = r[15:0];
      end
   end

endmodule

@@ rtl/trail_diffusion_decay_stencil.sv @@
// Grid of Q8.8 trail values with a wall bit per cell. Write and read items may issue
// back to back; a read returns its result in the cycle after start. A run item holds
// busy for pass_count passes (at least one): each cell takes five reads through the
// single read port of the trail memory plus three multiply steps and a scratch write,
// and each pass ends with a copy of the scratch memory back into the trail memory.
// The done strobe of every item lasts one cycle and cannot be stalled.
module trail_diffusion_decay_stencil (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tdds_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output tdds_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  tdds_pkg::csr_index_type         csr_index,
   input  logic [tdds_pkg::CSR_BITS-1:0]   csr_data
);
   import tdds_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_GATHER = 8'b00000010,
      ST_MUL1   = 8'b00000100,
      ST_MUL2   = 8'b00001000,
      ST_MUL3   = 8'b00010000,
      ST_STORE  = 8'b00100000,
      ST_COPY   = 8'b01000000,
      ST_DRAIN  = 8'b10000000
   } state_type;

   logic [15:0] trail_mem   [MAX_WIDTH*MAX_HEIGHT];
   logic [15:0] scratch_mem [MAX_WIDTH*MAX_HEIGHT];
   logic        wall_mem    [MAX_WIDTH*MAX_HEIGHT];

   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic [15:0]         gain_ff, limit_ff;
   logic [16:0]         decay_ff;
   logic [7:0]          passes_ff;

   state_type            state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [CELL_X_BITS-1:0] x_ff, x_in;
   logic [CELL_Y_BITS-1:0] y_ff, y_in;
   logic [7:0]           left_ff, left_in;
   logic [15:0]          c_ff, c_in;
   logic [17:0]          nsum_ff, nsum_in;
   logic                 wall_ff, wall_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_read_ff, rsp_read_in;
   logic                 cp_val_ff, cp_val_in;
   logic [ADDR_BITS-1:0] cp_addr_ff;

   logic [15:0]          trail_q_ff, scr_q_ff;
   logic                 wall_q_ff;

   logic [DIM_BITS-1:0]  w_eff, h_eff;
   logic [16:0]          decay_eff;
   logic                 accept, in_grid, x_last, y_last;
   logic [CELL_X_BITS-1:0] xl, xr;
   logic [CELL_Y_BITS-1:0] yu, yd;
   logic [ADDR_BITS-1:0] rd_addr, cell_addr, req_addr;
   logic                 st_we;
   logic [ADDR_BITS-1:0] st_waddr;
   logic [15:0]          st_wdata, math_res;
   logic                 sc_we;
   math_ctl_type         math_ctl;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         gain_ff   <= 16'd0;
         decay_ff  <= 17'd65536;
         limit_ff  <= 16'd65535;
         passes_ff <= 8'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRID_WIDTH:  width_ff  <= csr_data[DIM_BITS-1:0];
            CSR_GRID_HEIGHT: height_ff <= csr_data[DIM_BITS-1:0];
            CSR_DIFF_GAIN:   gain_ff   <= csr_data[15:0];
            CSR_DECAY:       decay_ff  <= csr_data;
            CSR_TRAIL_LIMIT: limit_ff  <= csr_data[15:0];
            CSR_PASS_COUNT:  passes_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = 9'd1;
      else if (width_ff > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = 9'd1;
      else if (height_ff > 9'(MAX_HEIGHT)) h_eff = 9'(MAX_HEIGHT);
      decay_eff = (decay_ff > 17'd65536) ? 17'd65536 : decay_ff;
   end

   assign in_grid  = ({1'b0, req_data.cell_x} < w_eff) && ({1'b0, req_data.cell_y} < h_eff);
   assign req_addr = {req_data.cell_y, req_data.cell_x};
   assign cell_addr = {y_ff, x_ff};
   assign x_last   = ({1'b0, x_ff} == w_eff - 9'd1);
   assign y_last   = ({1'b0, y_ff} == h_eff - 9'd1);
   assign xl = (x_ff == '0) ? x_ff : x_ff - 8'd1;
   assign xr = x_last ? x_ff : x_ff + 8'd1;
   assign yu = (y_ff == '0) ? y_ff : y_ff - 8'd1;
   assign yd = y_last ? y_ff : y_ff + 8'd1;

   always_comb begin
      case (step_ff)
         3'd0:    rd_addr = cell_addr;
         3'd1:    rd_addr = {y_ff, xl};
         3'd2:    rd_addr = {y_ff, xr};
         3'd3:    rd_addr = {yu, x_ff};
         3'd4:    rd_addr = {yd, x_ff};
         default: rd_addr = cell_addr;
      endcase
      if (state_ff == ST_IDLE) rd_addr = req_addr;
   end

   assign st_we    = cp_val_ff || (accept && req_data.op == OP_WRITE && in_grid);
   assign st_waddr = cp_val_ff ? cp_addr_ff : req_addr;
   assign st_wdata = cp_val_ff ? scr_q_ff : req_data.trail_in;
   assign sc_we    = (state_ff == ST_STORE);

   always_ff @(posedge clock) begin
      trail_q_ff <= trail_mem[rd_addr];
      wall_q_ff  <= wall_mem[rd_addr];
      scr_q_ff   <= scratch_mem[cell_addr];
      if (st_we) begin
         trail_mem[st_waddr] <= st_wdata;
      end
      if (accept && req_data.op == OP_WRITE && in_grid) begin
         wall_mem[req_addr] <= req_data.wall_in;
      end
      if (sc_we) begin
         scratch_mem[cell_addr] <= wall_ff ? 16'd0 : math_res;
      end
   end

   always_comb begin
      math_ctl.mul1 = (state_ff == ST_MUL1);
      math_ctl.mul2 = (state_ff == ST_MUL2);
      math_ctl.mul3 = (state_ff == ST_MUL3);
   end

   tdds_cell_math u_math (
      .clock  (clock),
      .ctl    (math_ctl),
      .center (c_ff),
      .nsum   (nsum_ff),
      .gain   (gain_ff),
      .decay  (decay_eff),
      .limit  (limit_ff),
      .result (math_res)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      left_in      = left_ff;
      c_in         = c_ff;
      nsum_in      = nsum_ff;
      wall_in      = wall_ff;
      rsp_valid_in = 1'b0;
      rsp_read_in  = 1'b0;
      cp_val_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_RUN) begin
                  state_in = ST_GATHER;
                  step_in  = 3'd0;
                  x_in     = '0;
                  y_in     = '0;
                  left_in  = (passes_ff == 8'd0) ? 8'd1 : passes_ff;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_read_in  = (req_data.op == OP_READ) && in_grid;
               end
            end
         end
         ST_GATHER: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               c_in    = trail_q_ff;
               wall_in = wall_q_ff;
               nsum_in = '0;
            end else if (step_ff != 3'd0) begin
               nsum_in = nsum_ff + {2'b0, trail_q_ff};
            end
            if (step_ff == 3'd5) state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_STORE;
         ST_STORE: begin
            state_in = ST_GATHER;
            step_in  = 3'd0;
            if (x_last) begin
               x_in = '0;
               if (y_last) begin
                  y_in     = '0;
                  state_in = ST_COPY;
               end else begin
                  y_in = y_ff + 8'd1;
               end
            end else begin
               x_in = x_ff + 8'd1;
            end
         end
         ST_COPY: begin
            cp_val_in = 1'b1;
            if (x_last) begin
               x_in = '0;
               if (y_last) begin
                  y_in     = '0;
                  state_in = ST_DRAIN;
               end else begin
                  y_in = y_ff + 8'd1;
               end
            end else begin
               x_in = x_ff + 8'd1;
            end
         end
         ST_DRAIN: begin
            step_in = 3'd0;
            if (left_ff == 8'd1) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               left_in  = left_ff - 8'd1;
               state_in = ST_GATHER;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
         cp_val_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_read_ff  <= rsp_read_in;
         cp_val_ff    <= cp_val_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      left_ff    <= left_in;
      c_ff       <= c_in;
      nsum_ff    <= nsum_in;
      wall_ff    <= wall_in;
      cp_addr_ff <= cell_addr;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_read_ff ? {trail_q_ff, wall_q_ff} : '0;

endmodule
